>>> rtl/isy_pkg.sv
// shared types, character codes and helper functions of the infix evaluator
package isy_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_POW    = 8'h5e;
  localparam logic [7:0] CH_MUL    = 8'h2a;
  localparam logic [7:0] CH_DIV    = 8'h2f;
  localparam logic [7:0] CH_ADD    = 8'h2b;
  localparam logic [7:0] CH_SUB    = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_PAREN,
    ERR_OVERFLOW,
    ERR_UNDERFLOW,
    ERR_DIV_ZERO,
    ERR_UNKNOWN
  } err_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         symbol_out;
    logic signed [31:0] value;
    logic [2:0]         error;
    logic               last_out;
  } rsp_t;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OP,
    CLS_DIGIT,
    CLS_UNKNOWN
  } sym_class_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_ACCEPT,
    CMD_PUSH_SYM,
    CMD_FLAG_UNK,
    CMD_FLAG_PAREN,
    CMD_OP_POP_RD,
    CMD_OP_POP_EMIT,
    CMD_EMIT_LOAD_RAM,
    CMD_EMIT_LOAD_SYM,
    CMD_EV_PUSH_DIGIT,
    CMD_FLAG_UNDER,
    CMD_VAL_RD_B,
    CMD_VAL_LATCH_B,
    CMD_ALU_START,
    CMD_VAL_WR,
    CMD_EMIT_RES,
    CMD_FINAL_RES,
    CMD_FLUSH_LAST
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CP_RD,
    S_CP_WT,
    S_OP_RD,
    S_OP_WT,
    S_OP_PUSH,
    S_END_CHK,
    S_FL_RD,
    S_FL_WT,
    S_FINAL_RD,
    S_FINAL_RES,
    S_FIN,
    S_EV,
    S_EV_RDA,
    S_EV_RDB,
    S_EV_ALU,
    S_EV_WAIT,
    S_EV_WR,
    S_EV_EMIT
  } ctl_state_t;

  typedef struct packed {
    sym_class_t cls;
    logic       end_flag;
    logic       op_empty;
    logic       val_lt2;
    logic       top_lparen;
    logic       rank_ge;
    logic       emit_digit;
    logic       unit_busy;
    logic       can_emit;
  } status_t;

  function automatic logic [1:0] rank(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      CH_POW:         r = 2'd3;
      CH_MUL, CH_DIV: r = 2'd2;
      CH_ADD, CH_SUB: r = 2'd1;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic sym_class_t classify(input logic [7:0] c);
    sym_class_t k;
    if (c == CH_SPACE || c == CH_TAB) k = CLS_SPACE;
    else if (c == CH_LPAREN) k = CLS_LPAREN;
    else if (c == CH_RPAREN) k = CLS_RPAREN;
    else if (rank(c) != 2'd0) k = CLS_OP;
    else if (c inside {[CH_ZERO:CH_NINE]}) k = CLS_DIGIT;
    else k = CLS_UNKNOWN;
    return k;
  endfunction

endpackage

>>> rtl/isy_ram.sv
// generic single write port ram with registered read
module isy_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/isy_datapath.sv
// stacks, arithmetic units and result registers of the infix evaluator
module isy_datapath import isy_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  req_t    req,
  output status_t st,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output rsp_t    rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(STACK_DEPTH);

  logic [7:0]    sym;
  logic          end_flag;
  logic [CW-1:0] opcnt;
  logic [CW-1:0] vc;
  err_t          err;
  logic [7:0]    emit_sym;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   r;
  logic          pend_v;
  rsp_t          pend;

  logic          div_busy;
  logic [4:0]    div_cnt;
  logic [32:0]   rem;
  logic [31:0]   quo;
  logic [31:0]   den;
  logic          div_neg;
  logic [32:0]   rem_sh;
  logic          div_bit;
  logic [31:0]   quo_n;

  logic          pow_busy;
  logic [31:0]   pexp;
  logic [31:0]   pbase;

  logic [CW-1:0] opm1;
  logic [CW-1:0] vm1;
  logic [CW-1:0] vm2;
  logic          op_full;
  logic          val_full;
  logic          op_we;
  logic [7:0]    op_rdata;
  logic          val_we;
  logic [31:0]   val_wdata;
  logic [AW-1:0] val_raddr;
  logic [31:0]   val_rdata;
  logic          can_emit;
  logic          rsp_load;
  err_t          fin_err;

  function automatic err_t flag(input err_t cur, input err_t e);
    return (cur == ERR_NONE) ? e : cur;
  endfunction

  assign opm1     = opcnt - CW'(1);
  assign vm1      = vc - CW'(1);
  assign vm2      = vc - CW'(2);
  assign op_full  = (opcnt == CNT_MAX);
  assign val_full = (vc == CNT_MAX);
  assign op_we    = (cmd == CMD_PUSH_SYM) && !op_full;
  assign val_we   = ((cmd == CMD_EV_PUSH_DIGIT) && !val_full) || (cmd == CMD_VAL_WR);
  assign val_wdata = (cmd == CMD_VAL_WR) ? r : {24'd0, emit_sym - CH_ZERO};
  assign val_raddr = (cmd == CMD_VAL_RD_B) ? vm2[AW-1:0] : vm1[AW-1:0];
  assign can_emit = !pend_v || !rsp_valid || rsp_ready;
  assign rsp_load = pend_v && (cmd inside {CMD_EMIT_RES, CMD_FINAL_RES, CMD_FLUSH_LAST});
  assign fin_err  = (vc == '0) ? flag(err, ERR_UNDERFLOW) : err;

  isy_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (opcnt[AW-1:0]),
    .wdata (sym),
    .raddr (opm1[AW-1:0]),
    .rdata (op_rdata)
  );

  isy_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (vc[AW-1:0]),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // restoring divider step on magnitudes
  assign rem_sh  = {rem[31:0], quo[31]};
  assign div_bit = (rem_sh >= {1'b0, den});
  assign quo_n   = {quo[30:0], div_bit};

  always_comb begin
    st.cls        = classify(sym);
    st.end_flag   = end_flag;
    st.op_empty   = (opcnt == '0);
    st.val_lt2    = (vc < CW'(2));
    st.top_lparen = (op_rdata == CH_LPAREN);
    st.rank_ge    = (rank(op_rdata) >= rank(sym));
    st.emit_digit = (emit_sym inside {[CH_ZERO:CH_NINE]});
    st.unit_busy  = div_busy || pow_busy;
    st.can_emit   = can_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opcnt     <= '0;
      vc        <= '0;
      err       <= ERR_NONE;
      pend_v    <= 1'b0;
      rsp_valid <= 1'b0;
      div_busy  <= 1'b0;
      pow_busy  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (cmd)
        CMD_ACCEPT: begin
          sym      <= req.symbol;
          end_flag <= req.end_of_expr;
        end
        CMD_PUSH_SYM: begin
          if (!op_full) opcnt <= opcnt + CW'(1);
          else err <= flag(err, ERR_OVERFLOW);
        end
        CMD_FLAG_UNK:   err <= flag(err, ERR_UNKNOWN);
        CMD_FLAG_PAREN: err <= flag(err, ERR_PAREN);
        CMD_OP_POP_RD:  opcnt <= opm1;
        CMD_OP_POP_EMIT: begin
          opcnt    <= opm1;
          emit_sym <= op_rdata;
        end
        CMD_EMIT_LOAD_RAM: emit_sym <= op_rdata;
        CMD_EMIT_LOAD_SYM: emit_sym <= sym;
        CMD_EV_PUSH_DIGIT: begin
          if (!val_full) vc <= vc + CW'(1);
          else err <= flag(err, ERR_OVERFLOW);
        end
        CMD_FLAG_UNDER: err <= flag(err, ERR_UNDERFLOW);
        CMD_VAL_RD_B:   a <= val_rdata;
        CMD_VAL_LATCH_B: begin
          b  <= val_rdata;
          vc <= vm2;
        end
        CMD_ALU_START: begin
          case (emit_sym)
            CH_ADD: r <= b + a;
            CH_SUB: r <= b - a;
            CH_MUL: r <= b * a;
            CH_DIV: begin
              if (a == 32'd0) begin
                err <= flag(err, ERR_DIV_ZERO);
                r   <= 32'd0;
              end else begin
                den      <= a[31] ? -a : a;
                quo      <= b[31] ? -b : b;
                rem      <= '0;
                div_neg  <= a[31] ^ b[31];
                div_cnt  <= '0;
                div_busy <= 1'b1;
              end
            end
            default: begin
              if (a[31]) begin
                if (b == 32'd1) r <= 32'd1;
                else if (b == 32'hFFFF_FFFF) r <= a[0] ? 32'hFFFF_FFFF : 32'd1;
                else begin
                  r <= 32'd0;
                  if (b == 32'd0) err <= flag(err, ERR_DIV_ZERO);
                end
              end else begin
                r        <= 32'd1;
                pbase    <= b;
                pexp     <= a;
                pow_busy <= (a != 32'd0);
              end
            end
          endcase
        end
        CMD_VAL_WR: vc <= vc + CW'(1);
        CMD_EMIT_RES: begin
          if (pend_v) begin
            rsp       <= pend;
            rsp_valid <= 1'b1;
          end
          pend   <= '{1'b0, emit_sym, 32'sd0, err, 1'b0};
          pend_v <= 1'b1;
        end
        CMD_FINAL_RES: begin
          if (pend_v) begin
            rsp       <= pend;
            rsp_valid <= 1'b1;
          end
          pend   <= '{1'b1, 8'd0, (vc == '0) ? 32'sd0 : val_rdata, fin_err, 1'b0};
          pend_v <= 1'b1;
          opcnt  <= '0;
          vc     <= '0;
          err    <= ERR_NONE;
        end
        CMD_FLUSH_LAST: begin
          if (pend_v) begin
            rsp       <= '{pend.kind, pend.symbol_out, pend.value, pend.error, 1'b1};
            rsp_valid <= 1'b1;
          end
          pend_v <= 1'b0;
        end
        default: begin
        end
      endcase

      if (div_busy) begin
        rem     <= div_bit ? (rem_sh - {1'b0, den}) : rem_sh;
        quo     <= quo_n;
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'd31) begin
          div_busy <= 1'b0;
          r        <= div_neg ? -quo_n : quo_n;
        end
      end

      if (pow_busy) begin
        if (pexp[0]) r <= r * pbase;
        pbase <= pbase * pbase;
        pexp  <= pexp >> 1;
        if (pexp[31:1] == 31'd0) pow_busy <= 1'b0;
      end
    end
  end

  a_op_bound: assert property (@(posedge clk) disable iff (rst) opcnt <= CNT_MAX)
    else $error("operator count beyond depth");
  a_val_bound: assert property (@(posedge clk) disable iff (rst) vc <= CNT_MAX)
    else $error("value count beyond depth");
  a_units_excl: assert property (@(posedge clk) disable iff (rst) !(div_busy && pow_busy))
    else $error("divider and power unit busy together");
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
      cmd == CMD_FINAL_RES |=> opcnt == '0 && vc == '0 && err == ERR_NONE && pend_v)
    else $error("state not cleared after final value");
  a_flush: assert property (@(posedge clk) disable iff (rst)
      cmd == CMD_FLUSH_LAST && pend_v |=> !pend_v && rsp_valid && rsp.last_out)
    else $error("last result not flushed");

endmodule

>>> rtl/isy_controller.sv
// sequencing state machine of the infix evaluator
module isy_controller import isy_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t st,
  output cmd_t    cmd
);

  ctl_state_t state;
  ctl_state_t state_next;
  ctl_state_t ret_state;
  ctl_state_t ret_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_END_CHK;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    cmd            = CMD_NOP;
    req_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd        = CMD_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.cls)
          CLS_SPACE:  state_next = S_END_CHK;
          CLS_LPAREN: begin
            cmd        = CMD_PUSH_SYM;
            state_next = S_END_CHK;
          end
          CLS_RPAREN: state_next = S_CP_RD;
          CLS_OP:     state_next = S_OP_RD;
          CLS_DIGIT: begin
            cmd            = CMD_EMIT_LOAD_SYM;
            ret_state_next = S_END_CHK;
            state_next     = S_EV;
          end
          default: begin
            cmd        = CMD_FLAG_UNK;
            state_next = S_END_CHK;
          end
        endcase
      end
      S_CP_RD: begin
        if (st.op_empty) begin
          cmd        = CMD_FLAG_PAREN;
          state_next = S_END_CHK;
        end else begin
          cmd        = CMD_OP_POP_RD;
          state_next = S_CP_WT;
        end
      end
      S_CP_WT: begin
        if (st.top_lparen) state_next = S_END_CHK;
        else begin
          cmd            = CMD_EMIT_LOAD_RAM;
          ret_state_next = S_CP_RD;
          state_next     = S_EV;
        end
      end
      S_OP_RD: state_next = st.op_empty ? S_OP_PUSH : S_OP_WT;
      S_OP_WT: begin
        if (st.rank_ge) begin
          cmd            = CMD_OP_POP_EMIT;
          ret_state_next = S_OP_RD;
          state_next     = S_EV;
        end else begin
          state_next = S_OP_PUSH;
        end
      end
      S_OP_PUSH: begin
        cmd        = CMD_PUSH_SYM;
        state_next = S_END_CHK;
      end
      S_END_CHK: state_next = st.end_flag ? S_FL_RD : S_FIN;
      S_FL_RD: begin
        if (st.op_empty) state_next = S_FINAL_RD;
        else begin
          cmd        = CMD_OP_POP_RD;
          state_next = S_FL_WT;
        end
      end
      S_FL_WT: begin
        if (st.top_lparen) begin
          cmd        = CMD_FLAG_PAREN;
          state_next = S_FL_RD;
        end else begin
          cmd            = CMD_EMIT_LOAD_RAM;
          ret_state_next = S_FL_RD;
          state_next     = S_EV;
        end
      end
      S_FINAL_RD: state_next = S_FINAL_RES;
      S_FINAL_RES: begin
        if (st.can_emit) begin
          cmd        = CMD_FINAL_RES;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.can_emit) begin
          cmd        = CMD_FLUSH_LAST;
          state_next = S_IDLE;
        end
      end
      S_EV: begin
        if (st.emit_digit) begin
          cmd        = CMD_EV_PUSH_DIGIT;
          state_next = S_EV_EMIT;
        end else if (st.val_lt2) begin
          cmd        = CMD_FLAG_UNDER;
          state_next = S_EV_EMIT;
        end else begin
          state_next = S_EV_RDA;
        end
      end
      S_EV_RDA: begin
        cmd        = CMD_VAL_RD_B;
        state_next = S_EV_RDB;
      end
      S_EV_RDB: begin
        cmd        = CMD_VAL_LATCH_B;
        state_next = S_EV_ALU;
      end
      S_EV_ALU: begin
        cmd        = CMD_ALU_START;
        state_next = S_EV_WAIT;
      end
      S_EV_WAIT: begin
        if (!st.unit_busy) state_next = S_EV_WR;
      end
      S_EV_WR: begin
        cmd        = CMD_VAL_WR;
        state_next = S_EV_EMIT;
      end
      S_EV_EMIT: begin
        if (st.can_emit) begin
          cmd        = CMD_EMIT_RES;
          state_next = ret_state;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/infix_shunting_yard_evaluator_core.sv
// top level of the shunting-yard infix evaluator
//
//   channel  direction  payload  handshake
//   req      in         req_t    req_valid / req_ready
//   rsp      out        rsp_t    rsp_valid / rsp_ready
//
// one request at a time; an operator first pops and evaluates each stacked operator
// of equal or higher rank; a closing paren or end pops the same way
// each divide runs in the bit-serial divider, each power in the
// square-and-multiply unit
// reset empties both stacks and clears the error; stack contents need none
// results wait in a pending stage and an output register; a stalled rsp
// side holds the sequencer at its next result
module infix_shunting_yard_evaluator_core import isy_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t st;

  isy_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  isy_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

>>> tb/sv/infix_shunting_yard_evaluator_core_tb.sv
// testbench of the shunting-yard infix evaluator: directed table, random expressions, predictor
module infix_shunting_yard_evaluator_core_tb;
  import isy_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       has_exp;
    logic [31:0] exp_value;
    logic [2:0] exp_error;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic [7:0]  opstk [DEPTH];
  int          op_n;
  logic [31:0] valstk [DEPTH];
  int          val_n;
  logic [2:0]  sticky;
  int          res_n;

  rsp_t expected_q[$];
  int   typed_value_q[$];
  int   typed_error_q[$];
  int   fails = 0;
  int   sent = 0;
  int   got = 0;
  int   exprs = 0;
  int   idle_cnt = 0;
  bit   quiet = 1'b0;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;

  row_t directed[$];

  always #2 clk = ~clk;

  infix_shunting_yard_evaluator_core uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  function automatic int prec(input logic [7:0] c);
    if (c == CH_POW) return 3;
    if (c == CH_MUL || c == CH_DIV) return 2;
    if (c == CH_ADD || c == CH_SUB) return 1;
    return 0;
  endfunction

  function automatic void note_err(input err_t e);
    if (sticky == ERR_NONE) sticky = e;
  endfunction

  function automatic logic [31:0] raise(input logic [31:0] b, input logic [31:0] a);
    logic [31:0] r;
    r = 32'd1;
    if (a[31]) begin
      if (b == 32'd1) return 32'd1;
      if (b == 32'hffffffff) return a[0] ? 32'hffffffff : 32'd1;
      if (b == 32'd0) note_err(ERR_DIV_ZERO);
      return 32'd0;
    end
    while (a != 0) begin
      if (a[0]) r = r * b;
      b = b * b;
      a = a >> 1;
    end
    return r;
  endfunction

  function automatic void apply_symbol(input logic [7:0] c);
    logic [31:0] a, b, r;
    rsp_t o;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (val_n >= DEPTH) note_err(ERR_OVERFLOW);
      else begin
        valstk[val_n] = {24'd0, c - CH_ZERO};
        val_n++;
      end
    end else if (val_n < 2) begin
      note_err(ERR_UNDERFLOW);
    end else begin
      a = valstk[val_n-1];
      b = valstk[val_n-2];
      val_n -= 2;
      case (c)
        CH_ADD: r = b + a;
        CH_SUB: r = b - a;
        CH_MUL: r = b * a;
        CH_DIV: begin
          if (a == 0) begin
            note_err(ERR_DIV_ZERO);
            r = 0;
          end else if (b == 32'h80000000 && a == 32'hffffffff) r = b;
          else r = $signed(b) / $signed(a);
        end
        default: r = raise(b, a);
      endcase
      valstk[val_n] = r;
      val_n++;
    end
    if (res_n < DEPTH) begin
      o = '0;
      o.symbol_out = c;
      o.error = sticky;
      expected_q.push_back(o);
      typed_value_q.push_back(-1);
      typed_error_q.push_back(-1);
      res_n++;
    end
  endfunction

  function automatic void predict_request(input logic [7:0] s, input logic last,
                                          input bit has_exp, input logic [31:0] ev,
                                          input logic [2:0] ee);
    logic [7:0] c;
    rsp_t o;
    int prev_n;
    prev_n = expected_q.size();
    res_n = 0;
    if (s != CH_SPACE && s != CH_TAB) begin
      if (s == CH_LPAREN) begin
        if (op_n < DEPTH) begin
          opstk[op_n] = s;
          op_n++;
        end else note_err(ERR_OVERFLOW);
      end else if (s == CH_RPAREN) begin
        forever begin
          if (op_n == 0) begin
            note_err(ERR_PAREN);
            break;
          end
          op_n--;
          c = opstk[op_n];
          if (c == CH_LPAREN) break;
          apply_symbol(c);
        end
      end else if (prec(s) > 0) begin
        while (op_n > 0 && prec(opstk[op_n-1]) >= prec(s)) begin
          op_n--;
          apply_symbol(opstk[op_n]);
        end
        if (op_n < DEPTH) begin
          opstk[op_n] = s;
          op_n++;
        end else note_err(ERR_OVERFLOW);
      end else if (s >= CH_ZERO && s <= CH_NINE) begin
        apply_symbol(s);
      end else note_err(ERR_UNKNOWN);
    end
    if (last) begin
      while (op_n > 0) begin
        op_n--;
        c = opstk[op_n];
        if (c == CH_LPAREN) note_err(ERR_PAREN);
        else apply_symbol(c);
      end
      o = '0;
      o.kind = 1'b1;
      if (val_n == 0) note_err(ERR_UNDERFLOW);
      else o.value = valstk[val_n-1];
      o.error = sticky;
      expected_q.push_back(o);
      typed_value_q.push_back(has_exp ? int'(ev) : -1);
      typed_error_q.push_back(has_exp ? int'(ee) : -1);
      op_n = 0;
      val_n = 0;
      sticky = ERR_NONE;
      exprs++;
    end
    if (expected_q.size() > prev_n) expected_q[$].last_out = 1'b1;
  endfunction

  task automatic send(input logic [7:0] s, input logic last, input bit has_exp = 0,
                      input logic [31:0] ev = 0, input logic [2:0] ee = 0);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req.symbol <= s;
    req.end_of_expr <= last;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_request(s, last, has_exp, ev, ee);
    sent++;
  endtask

  task automatic drop_valid();
    req_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      3: return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // well-formed expression, occasionally spaced, parenthesized or corrupted
  task automatic send_expression();
    int terms, depth_open;
    logic [7:0] s;
    terms = $urandom_range(1, 6);
    depth_open = 0;
    for (int i = 0; i < terms; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send(CH_LPAREN, 1'b0);
        depth_open++;
      end
      if ($urandom_range(0, 6) == 0) send($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
      send(rand_digit(), 1'b0);
      if (depth_open > 0 && $urandom_range(0, 2) == 0) begin
        send(CH_RPAREN, 1'b0);
        depth_open--;
      end
      if ($urandom_range(0, 14) == 0) begin
        s = 8'($urandom_range(0, 255));
        send(s, 1'b0);
      end
      if (i != terms - 1) send(rand_op(), 1'b0);
    end
    while (depth_open > 0 && $urandom_range(0, 5) != 0) begin
      send(CH_RPAREN, 1'b0);
      depth_open--;
    end
    case ($urandom_range(0, 5))
      0: send(CH_RPAREN, 1'b1);
      1: send(rand_op(), 1'b1);
      2: send(8'($urandom_range(0, 255)), 1'b1);
      default: send(CH_SPACE, 1'b1);
    endcase
  endtask

  function automatic void add_row(input logic [7:0] s, input logic last, input bit h = 0,
                                  input logic [31:0] v = 0, input logic [2:0] e = 0);
    row_t r;
    r.sym = s;
    r.last = last;
    r.has_exp = h;
    r.exp_value = v;
    r.exp_error = e;
    directed.push_back(r);
  endfunction

  // result checking
  always @(posedge clk) begin
    rsp_t exp_rsp;
    int tv, te;
    if (!rst && rsp_valid && rsp_ready) begin
      got++;
      idle_cnt <= 0;
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d symbol=%h", rsp.kind, rsp.symbol_out);
        fails++;
      end else begin
        exp_rsp = expected_q.pop_front();
        tv = typed_value_q.pop_front();
        te = typed_error_q.pop_front();
        if (rsp.kind !== exp_rsp.kind) begin
          $error("kind expected %0d actual %0d", exp_rsp.kind, rsp.kind); fails++;
        end
        if (rsp.symbol_out !== exp_rsp.symbol_out) begin
          $error("symbol_out expected %h actual %h", exp_rsp.symbol_out, rsp.symbol_out);
          fails++;
        end
        if (rsp.value !== exp_rsp.value) begin
          $error("value expected %0d actual %0d", exp_rsp.value, rsp.value); fails++;
        end
        if (rsp.error !== exp_rsp.error) begin
          $error("error expected %0d actual %0d", exp_rsp.error, rsp.error); fails++;
        end
        if (rsp.last_out !== exp_rsp.last_out) begin
          $error("last_out expected %0d actual %0d", exp_rsp.last_out, rsp.last_out);
          fails++;
        end
        if (tv != -1 && rsp.value !== tv) begin
          $error("value expected %0d actual %0d", tv, rsp.value); fails++;
        end
        if (te != -1 && rsp.error !== te[2:0]) begin
          $error("error expected %0d actual %0d", te, rsp.error); fails++;
        end
      end
    end else if (!rst && req_valid && req_ready) begin
      idle_cnt <= 0;
    end else if (!rst) begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp_ready <= 1'b0;
        n = 400;
        repeat (n) @(posedge clk);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    op_n = 0;
    val_n = 0;
    sticky = ERR_NONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, every operator, error cases
    add_row(CH_SPACE, 1'b1, 1, 32'd0, ERR_UNDERFLOW);
    add_row(CH_NINE, 1'b1, 1, 32'd9, ERR_NONE);
    add_row(CH_ZERO, 1'b0);
    add_row(CH_DIV, 1'b0);
    add_row(CH_ZERO, 1'b1, 1, 32'd0, ERR_DIV_ZERO);
    add_row(CH_ZERO, 1'b0);
    add_row(CH_SUB, 1'b0);
    add_row(CH_NINE, 1'b0);
    add_row(CH_POW, 1'b0);
    add_row(CH_NINE, 1'b0);
    add_row(CH_MUL, 1'b0);
    add_row(CH_LPAREN, 1'b0);
    add_row(CH_NINE, 1'b0);
    add_row(CH_ADD, 1'b0);
    add_row(CH_TAB, 1'b0);
    add_row(CH_NINE, 1'b0);
    add_row(CH_RPAREN, 1'b1);
    add_row(CH_RPAREN, 1'b1, 1, 32'd0, ERR_PAREN);
    add_row(8'hff, 1'b1, 1, 32'd0, ERR_UNKNOWN);
    add_row(CH_ADD, 1'b1, 1, 32'd0, ERR_UNDERFLOW);
    add_row(CH_LPAREN, 1'b0);
    add_row(CH_SEVEN_OR_DIGIT(), 1'b1, 1, 32'd7, ERR_PAREN);
    foreach (directed[i])
      send(directed[i].sym, directed[i].last, directed[i].has_exp,
           directed[i].exp_value, directed[i].exp_error);

    // operator stack overflow, then value stack overflow
    for (int i = 0; i < DEPTH + 2; i++) send(CH_LPAREN, 1'b0);
    send(CH_ONE_DIGIT(), 1'b1);
    for (int i = 0; i < DEPTH + 2; i++) send(rand_digit(), 1'b0);
    send(CH_SPACE, 1'b1);
    // negative exponent: 0-1 as exponent
    send(CH_ZERO + 8'd2, 1'b0); send(CH_POW, 1'b0); send(CH_LPAREN, 1'b0);
    send(CH_ZERO, 1'b0); send(CH_SUB, 1'b0); send(CH_ZERO + 8'd1, 1'b0);
    send(CH_RPAREN, 1'b1);

    // long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send_expression();

    while (sent < 390) send_expression();
    quiet = 1'b1;
    while (sent < 450) send_expression();
    // every bit of the symbol field
    for (int i = 0; i < 8; i++) send(8'(1 << i), 1'b0);
    send(8'hff, 1'b1);
    drop_valid();
    stim_done = 1'b1;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests in %0d expressions, %0d results checked",
             sent, exprs, got);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  function automatic logic [7:0] CH_SEVEN_OR_DIGIT();
    return CH_ZERO + 8'd7;
  endfunction

  function automatic logic [7:0] CH_ONE_DIGIT();
    return CH_ZERO + 8'd1;
  endfunction

endmodule
